// File: rtl/core/button_debounce_hold_events_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Clocked on clock, quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_HOLD_EVENTS_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_EVENTS_ASSERT_SVH

// plain property check
`define BDHE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication check
`define BDHE_ASSERT_IMP(lbl, ante, cons, msg) \
   `BDHE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/core/bdhe_pkg.sv
// ----------------------------------------------------------------------------
// bdhe_pkg
// Shared constants and types of the button debounce and hold event block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdhe_pkg;

   localparam int NUM_KEYS     = 9;
   localparam int HISTORY_BITS = 16;
   localparam int HOLD_W       = 10;
   localparam int MASK_W       = NUM_KEYS;
   localparam int EV_W         = 3;
   localparam int EVENTS_W     = EV_W * NUM_KEYS;
   localparam int CFG_W        = 10;
   localparam int CSR_IDX_W    = 1;
   localparam int KEY_W        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   localparam int REQ_TDATA_W  = ((NUM_KEYS + 7) / 8) * 8;
   localparam int RSP_PAY_W    = EVENTS_W + MASK_W;
   localparam int RSP_TDATA_W  = ((RSP_PAY_W + 7) / 8) * 8;

   localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

   localparam logic [HISTORY_BITS-1:0] HIST_FULL   = {HISTORY_BITS{1'b1}};
   localparam logic [HISTORY_BITS-1:0] HIST_ALMOST = HIST_FULL >> 1;
   localparam logic [HISTORY_BITS-1:0] HIST_TOP    = ~HIST_ALMOST;

   localparam logic [HOLD_W-1:0] HOLD_LIMIT_RESET = HOLD_W'(512);

   typedef enum logic [EV_W-1:0] {
      EV_NONE          = 3'd0,
      EV_PRESSED       = 3'd1,
      EV_RELEASED      = 3'd2,
      EV_HELD          = 3'd3,
      EV_HELD_RELEASED = 3'd4
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_HIGH_MASK = 1'b0,
      CSR_HOLD_LIMIT       = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [HOLD_W-1:0]       hold;
      logic [HISTORY_BITS-1:0] hist;
   } key_entry_type;

endpackage

`default_nettype wire

// File: rtl/core/button_debounce_hold_events.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_events
// Shift-register debouncer with press, release and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one scan request: the raw pin levels of all buttons.
//  - rsp_* returns one result per request: a 3-bit event per button and the
//    mask of buttons whose whole history is active.
//  - csr_* writes the polarity mask (index 0) and the hold limit (index 1);
//    write only while no request is in flight.
// Flow:
//  - buttons are handled one per cycle through a state RAM with one read and
//    one write port (read, update, write back), so a request occupies the RAM
//    until its last button is issued; the next request can be taken in the
//    cycle that issues the last button, unless two results are owed.
//  - the result enters the output register after the last button is updated.
// Reset clears the per-button valid bits (state reads as zero), the config
// registers (mask 0, hold limit 512) and all pending results.
// A stalled receiver is absorbed by the output register plus one skid entry;
// req_tready drops while two results are owed (in flight or waiting) and
// rises again once one of them is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "button_debounce_hold_events_assert.svh"

module button_debounce_hold_events (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [bdhe_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [8:0] pin_levels
   // result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [bdhe_pkg::RSP_TDATA_W-1:0]        rsp_tdata,  // [26:0] events_packed,
                                                               // [35:27] pressed_mask
   // config write port
   input  wire logic                               csr_we,
   input  wire logic [bdhe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bdhe_pkg::CFG_W-1:0]         csr_wdata
);

   // ---------------------------------------------------------------- config
   logic [bdhe_pkg::MASK_W-1:0] active_high_ff;
   logic [bdhe_pkg::HOLD_W-1:0] hold_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff <= '0;
         hold_limit_ff  <= bdhe_pkg::HOLD_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (bdhe_pkg::csr_reg_type'(csr_index))
            bdhe_pkg::CSR_ACTIVE_HIGH_MASK: begin
               active_high_ff <= csr_wdata[bdhe_pkg::MASK_W-1:0];
            end
            bdhe_pkg::CSR_HOLD_LIMIT: begin
               hold_limit_ff <= csr_wdata[bdhe_pkg::HOLD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- issue
   // One button per cycle: the RAM read for key_ff goes out this cycle.
   logic                          busy_ff, busy_in;
   logic [bdhe_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [bdhe_pkg::NUM_KEYS-1:0] pins_ff, pins_in;
   logic [1:0]                    occ_ff, occ_in;   // requests taken, results not yet taken
   logic                          issue, issue_last, req_acc, rsp_pop;

   assign issue      = busy_ff;
   assign issue_last = busy_ff && (key_ff == bdhe_pkg::LAST_KEY);
   assign req_tready = (!busy_ff || issue_last) && (occ_ff != 2'd2);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      busy_in = busy_ff;
      key_in  = key_ff;
      pins_in = pins_ff;
      if (req_acc) begin
         busy_in = 1'b1;
         key_in  = '0;
         pins_in = req_tdata[bdhe_pkg::NUM_KEYS-1:0];
      end else if (issue_last) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         key_in = key_ff + bdhe_pkg::KEY_W'(1);
      end
      occ_in = occ_ff + {1'b0, req_acc} - {1'b0, rsp_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         occ_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         occ_ff  <= occ_in;
      end
      key_ff  <= key_in;
      pins_ff <= pins_in;
   end

   // ---------------------------------------------------------------- state RAM
   bdhe_pkg::key_entry_type       mem [bdhe_pkg::NUM_KEYS];
   bdhe_pkg::key_entry_type       mem_q_ff;
   bdhe_pkg::key_entry_type       wr_data;
   bdhe_pkg::key_entry_type       fwd_data_ff;
   logic                          fwd_ff;
   logic                          rd_vld_ff;
   logic [bdhe_pkg::NUM_KEYS-1:0] vld_ff;   // entry written since reset

   logic                          s1_valid_ff, s1_last_ff, s1_active_ff;
   logic [bdhe_pkg::KEY_W-1:0]    s1_key_ff;

   always_ff @(posedge clock) begin
      if (issue) begin
         mem_q_ff <= mem[key_ff];
      end
      if (s1_valid_ff) begin
         mem[s1_key_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (s1_valid_ff) begin
            vld_ff[s1_key_ff] <= 1'b1;
         end
         s1_valid_ff <= issue;
      end
      // read and write of the same entry in one cycle: take the write data
      fwd_ff       <= s1_valid_ff && (s1_key_ff == key_ff);
      fwd_data_ff  <= wr_data;
      rd_vld_ff    <= vld_ff[key_ff];
      s1_key_ff    <= key_ff;
      s1_last_ff   <= issue_last;
      // polarity 1: high pin active; 0: low pin active
      s1_active_ff <= ~(pins_ff[key_ff] ^ active_high_ff[key_ff]);
   end

   // ---------------------------------------------------------------- update
   bdhe_pkg::key_entry_type         old_entry;
   logic [bdhe_pkg::HISTORY_BITS-1:0] hist_now;
   logic [bdhe_pkg::HOLD_W-1:0]     hold_inc;
   bdhe_pkg::event_type             ev;
   logic [bdhe_pkg::EVENTS_W-1:0]   acc_ev_ff, acc_ev_in;
   logic [bdhe_pkg::MASK_W-1:0]     acc_mask_ff, acc_mask_in;

   always_comb begin
      if (fwd_ff) begin
         old_entry = fwd_data_ff;
      end else if (rd_vld_ff) begin
         old_entry = mem_q_ff;
      end else begin
         old_entry = '0;
      end

      hist_now = {old_entry.hist[bdhe_pkg::HISTORY_BITS-2:0], s1_active_ff};
      hold_inc = old_entry.hold + bdhe_pkg::HOLD_W'(1);

      wr_data.hist = hist_now;
      wr_data.hold = old_entry.hold;
      ev           = bdhe_pkg::EV_NONE;

      if (old_entry.hist == bdhe_pkg::HIST_ALMOST && hist_now == bdhe_pkg::HIST_FULL) begin
         wr_data.hold = '0;
         ev           = bdhe_pkg::EV_PRESSED;
      end else if (old_entry.hist == bdhe_pkg::HIST_TOP && hist_now == '0) begin
         ev           = (old_entry.hold < hold_limit_ff) ? bdhe_pkg::EV_RELEASED
                                                         : bdhe_pkg::EV_HELD_RELEASED;
         wr_data.hold = '0;
      end else if (hist_now == bdhe_pkg::HIST_FULL) begin
         // counts up to the limit and stays there
         if (old_entry.hold < hold_limit_ff) begin
            wr_data.hold = hold_inc;
            if (hold_inc == hold_limit_ff) begin
               ev = bdhe_pkg::EV_HELD;
            end
         end
      end

      // accumulate the packed result, fresh at the first button
      if (s1_key_ff == '0) begin
         acc_ev_in   = '0;
         acc_mask_in = '0;
      end else begin
         acc_ev_in   = acc_ev_ff;
         acc_mask_in = acc_mask_ff;
      end
      acc_ev_in[s1_key_ff*bdhe_pkg::EV_W +: bdhe_pkg::EV_W] = ev;
      acc_mask_in[s1_key_ff] = (hist_now == bdhe_pkg::HIST_FULL);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         acc_ev_ff   <= acc_ev_in;
         acc_mask_ff <= acc_mask_in;
      end
   end

   // ---------------------------------------------------------------- output
   // Output register plus one skid entry; the skid entry is always the newer.
   logic                             push;
   logic [bdhe_pkg::RSP_PAY_W-1:0]   push_data;
   logic                             rsp_vld_ff, rsp_vld_in, skid_vld_ff, skid_vld_in;
   logic [bdhe_pkg::RSP_PAY_W-1:0]   rsp_ff, rsp_in, skid_ff, skid_in;

   assign push      = s1_valid_ff && s1_last_ff;
   assign push_data = {acc_mask_in, acc_ev_in};
   assign rsp_pop   = rsp_vld_ff && rsp_tready;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_in      = rsp_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (rsp_pop) begin
         if (skid_vld_ff) begin
            rsp_in      = skid_ff;
            skid_vld_in = push;
            skid_in     = push_data;
         end else begin
            rsp_vld_in = push;
            rsp_in     = push_data;
         end
      end else if (push) begin
         if (rsp_vld_ff) begin
            skid_vld_in = 1'b1;
            skid_in     = push_data;
         end else begin
            rsp_vld_in = 1'b1;
            rsp_in     = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = bdhe_pkg::RSP_TDATA_W'(rsp_ff);

   // ---------------------------------------------------------------- checks
   `BDHE_ASSERT_IMP(a_push_has_room, push, !(rsp_vld_ff && skid_vld_ff),
                    "result lost: both slots full")
   `BDHE_ASSERT_IMP(a_skid_behind_rsp, skid_vld_ff, rsp_vld_ff,
                    "skid entry without output entry")
   `BDHE_ASSERT(a_occ_tracks,
                occ_ff == (2'(rsp_vld_ff) + 2'(skid_vld_ff) + 2'(busy_ff)
                           + 2'(s1_valid_ff && s1_last_ff)),
                "request count out of step")
   `BDHE_ASSERT_IMP(a_s1_follows_issue, s1_valid_ff, $past(busy_ff),
                    "update without a preceding read")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nine-button debouncer with hold events. Scan
// requests come from a queue filled in phases. Each phase first sets the
// polarity mask and the hold limit. Button levels follow bouncy runs of random
// length, with glitches and noise. An own scan predictor checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import bdhe_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;  // idle cycles allowed with no handshake
   localparam int DRAIN_CYCLES   = 20;    // wait after the last result, with margin

   typedef struct packed {
      logic [MASK_W-1:0]   pressed;
      logic [EVENTS_W-1:0] events;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [8:0] pin_levels
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [26:0] events_packed, [35:27] pressed_mask
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CFG_W-1:0]       csr_wdata  = '0;

   // own copy of the block state and its registers
   logic [HISTORY_BITS-1:0] key_history [NUM_KEYS];
   logic [HOLD_W-1:0]       key_hold    [NUM_KEYS];
   logic [MASK_W-1:0]       polarity_mask;
   logic [HOLD_W-1:0]       hold_limit_cfg;

   // stimulus shaping: current level and remaining run length per button
   logic key_level [NUM_KEYS];
   int   key_run   [NUM_KEYS];

   logic [MASK_W-1:0] pending_pins [$];   // requests not yet taken by the block
   scan_result_type   expected_scans [$];  // predicted results, oldest first

   logic calm      = 1'b0;   // no idling on either side while set
   logic req_fired = 1'b0;   // the request on the bus was taken at the last edge
   int   mismatches = 0;
   int   quiet_cycles = 0;

   button_debounce_hold_events u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // One scan tick of all buttons: shifts histories, updates hold counters
   // and returns the packed events plus the stable-pressed mask.
   function automatic scan_result_type debounce_scan(input logic [MASK_W-1:0] pins);
      scan_result_type         res;
      logic [HISTORY_BITS-1:0] prev;
      logic [HISTORY_BITS-1:0] next;
      logic                    act;
      event_type               ev;
      res = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         prev = key_history[k];
         act  = polarity_mask[k] ? pins[k] : ~pins[k];
         next = {prev[HISTORY_BITS-2:0], act};
         ev   = EV_NONE;
         key_history[k] = next;
         if (prev == HIST_ALMOST && next == HIST_FULL) begin
            // press tick clears the counter without counting itself
            key_hold[k] = '0;
            ev = EV_PRESSED;
         end else if (prev == HIST_TOP && next == '0) begin
            if (key_hold[k] < hold_limit_cfg) ev = EV_RELEASED;
            else                              ev = EV_HELD_RELEASED;
            key_hold[k] = '0;
         end else if (next == HIST_FULL && key_hold[k] < hold_limit_cfg) begin
            // counter saturates at the limit; a lowered limit freezes it
            key_hold[k] = key_hold[k] + 1'b1;
            if (key_hold[k] == hold_limit_cfg) ev = EV_HELD;
         end
         res.events[EV_W*k +: EV_W] = ev;
         res.pressed[k] = (next == HIST_FULL);
      end
      return res;
   endfunction

   // Request side: prediction on acceptance at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_scans.push_back(debounce_scan(req_tdata[MASK_W-1:0]));
         void'(pending_pins.pop_front());
         req_fired = 1'b1;
      end
   end

   // Request driver: changes at the falling edge, holds a request until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         req_fired = 1'b0;
         if (pending_pins.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_TDATA_W'(pending_pins[0]);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 11);
   end

   // Result monitor.
   always @(posedge clock) begin
      scan_result_type want;
      logic [EVENTS_W-1:0] got_events;
      logic [MASK_W-1:0]   got_pressed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_events  = rsp_tdata[EVENTS_W-1:0];
         got_pressed = rsp_tdata[EVENTS_W +: MASK_W];
         if (expected_scans.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result events=%h pressed=%h",
                        got_events, got_pressed);
         end else begin
            want = expected_scans.pop_front();
            if (got_events !== want.events || got_pressed !== want.pressed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result mismatch: events exp %h got %h, pressed exp %h got %h",
                           want.events, got_events, want.pressed, got_pressed);
            end
         end
      end
   end

   // Watchdog: too long without any handshake means the block is stuck.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Register write at a falling edge; the caller lowers csr_we afterwards.
   task automatic write_reg(input csr_reg_type idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_ACTIVE_HIGH_MASK) polarity_mask  = val[MASK_W-1:0];
      else                             hold_limit_cfg = val[HOLD_W-1:0];
   endtask

   task automatic set_config(input logic [MASK_W-1:0] mask, input logic [HOLD_W-1:0] limit);
      write_reg(CSR_ACTIVE_HIGH_MASK, CFG_W'(mask));
      write_reg(CSR_HOLD_LIMIT, CFG_W'(limit));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Block idle: every request taken, every result back, pipeline drained.
   task automatic wait_idle();
      wait (pending_pins.size() == 0 && expected_scans.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Bouncy button levels: mostly stable runs long enough to press and hold,
   // some short bounces, rare single-scan glitches and a little pure noise.
   task automatic queue_scans(input int count);
      logic [MASK_W-1:0] pins;
      int pick;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (key_run[k] == 0) begin
               key_level[k] = ~key_level[k];
               pick = $urandom_range(99);
               if (pick < 15)      key_run[k] = $urandom_range(1, 4);
               else if (pick < 85) key_run[k] = $urandom_range(17, 45);
               else                key_run[k] = $urandom_range(46, 160);
            end
            key_run[k]--;
            pins[k] = ($urandom_range(99) < 3) ? ~key_level[k] : key_level[k];
         end
         if ($urandom_range(99) < 5) pins = MASK_W'($urandom);
         pending_pins.push_back(pins);
      end
   endtask

   initial begin
      logic [MASK_W-1:0] mask;
      logic [HOLD_W-1:0] limit;
      int pick;

      for (int k = 0; k < NUM_KEYS; k++) begin
         key_history[k] = '0;
         key_hold[k]    = '0;
         key_level[k]   = 1'b0;
         key_run[k]     = $urandom_range(0, 20);
      end
      polarity_mask  = '0;
      hold_limit_cfg = HOLD_LIMIT_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: all buttons pressed under a mixed polarity, held at a
      // limit of two, then the pin extremes and alternating patterns
      mask = 9'h0A5;
      set_config(mask, 10'd2);
      for (int n = 0; n < 18; n++) pending_pins.push_back(mask);
      pending_pins.push_back(9'h000);
      pending_pins.push_back(9'h1FF);
      pending_pins.push_back(9'h155);
      pending_pins.push_back(9'h0AA);
      pending_pins.push_back(~mask);
      pending_pins.push_back(mask);
      wait_idle();

      // random phases; the first few pin the register extremes, including a
      // zero hold limit and limits that drop below running counters
      for (int phase = 0; phase < 25; phase++) begin
         pick = $urandom_range(99);
         if (pick < 15)      mask = '0;
         else if (pick < 30) mask = '1;
         else                mask = MASK_W'($urandom);
         pick = $urandom_range(99);
         if (phase == 0)      limit = 10'd0;
         else if (phase == 1) limit = 10'd1;
         else if (phase == 2) limit = 10'd1023;
         else if (pick < 50)  limit = HOLD_W'($urandom_range(1, 12));
         else if (pick < 80)  limit = HOLD_W'($urandom_range(13, 60));
         else if (pick < 88)  limit = 10'd0;
         else if (pick < 94)  limit = 10'd1;
         else                 limit = 10'd1023;
         set_config(mask, limit);
         calm = (phase >= 10 && phase < 14);
         queue_scans(25);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
